/* rtl/gff_pkg.sv */
// ----------------------------------------------------------------------------
// gff_pkg
// Shared types and constants of the gap friction flag hysteresis block:
// sequencer states, arithmetic unit requests, modes, register indexes,
// stage codes and register reset values.
// ----------------------------------------------------------------------------
package gff_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int ER_FRAC    = 16;

  localparam logic [1:0] MODE_TRIAL  = 2'd0;
  localparam logic [1:0] MODE_COMMIT = 2'd1;
  localparam logic [1:0] MODE_REVERT = 2'd2;
  localparam logic [1:0] MODE_START  = 2'd3;

  localparam logic [2:0] CFG_SLIP_FORCE        = 3'd0;
  localparam logic [2:0] CFG_GAP_STIFFNESS     = 3'd1;
  localparam logic [2:0] CFG_GAP_WIDTH         = 3'd2;
  localparam logic [2:0] CFG_ACTIVATION_FORCE  = 3'd3;
  localparam logic [2:0] CFG_INITIAL_STIFFNESS = 3'd4;
  localparam logic [2:0] CFG_POST_STIFFNESS    = 3'd5;
  localparam logic [2:0] CFG_ENERGY_RATIO      = 3'd6;

  localparam logic [1:0] STAGE_GAP = 2'd1;
  localparam logic [1:0] STAGE_SC  = 2'd2;

  localparam logic [30:0] RST_SLIP_FORCE        = 31'd65536;
  localparam logic [30:0] RST_GAP_STIFFNESS     = 31'd65536;
  localparam logic [30:0] RST_GAP_WIDTH         = 31'd65536;
  localparam logic [30:0] RST_ACTIVATION_FORCE  = 31'd65536;
  localparam logic [30:0] RST_INITIAL_STIFFNESS = 31'd65536;
  localparam logic [30:0] RST_POST_STIFFNESS    = 31'd6554;
  localparam logic [16:0] RST_ENERGY_RATIO      = 17'd32768;

  typedef enum logic [1:0] {
    OP_MULF,
    OP_MULQ,
    OP_DIV
  } arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_R_SLIP,
    ST_R_SLIPW,
    ST_R_UYW,
    ST_R_AW,
    ST_R_ALW,
    ST_R_MW,
    ST_R_C,
    ST_R_CW,
    ST_R_TW,
    ST_T_D,
    ST_T_CASE,
    ST_T_PREP1,
    ST_T_PREP2,
    ST_FR_START,
    ST_FR_MW,
    ST_FR_CLAMP,
    ST_FL_START,
    ST_FL_M1W,
    ST_FL_M2W,
    ST_FL_M3W,
    ST_FL_K,
    ST_FL_SEL,
    ST_SUB_END,
    ST_T_TAN,
    ST_T_TANW,
    ST_OUT
  } state_t;

endpackage

/* rtl/gff_arith.sv */
// ----------------------------------------------------------------------------
// gff_arith
// Bit-serial arithmetic unit: shifted saturating multiply, one multiplier
// bit per cycle, and saturating fixed-point divide, one quotient bit per
// cycle. Results truncate toward zero.
// ----------------------------------------------------------------------------
module gff_arith #(
  parameter int DATA_WIDTH = gff_pkg::DATA_WIDTH,
  parameter int FRAC_BITS  = gff_pkg::FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  gff_pkg::arith_req_t          req,
  input  logic signed [DATA_WIDTH-1:0] opa,
  input  logic signed [DATA_WIDTH-1:0] opb,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] res
);

  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int NW = W + F;
  localparam int CW = $clog2(NW);
  localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  logic                run;
  logic                fin;
  logic                dz;
  logic                neg;
  logic                asign;
  logic                azero;
  gff_pkg::arith_op_t  op;
  logic [W-1:0]        xm;
  logic [W-1:0]        acc;
  logic [NW-1:0]       sr;
  logic [W-1:0]        rem;
  logic [CW-1:0]       cnt;

  logic [W-1:0]        mag_a;
  logic [W-1:0]        mag_b;
  logic [W:0]          msum;
  logic [W:0]          rtry;
  logic [W:0]          rdiff;
  logic                qbit;
  logic [CW-1:0]       last;
  logic [2*W-1:0]      prod;
  logic [2*W-1:0]      shv;
  logic                big;
  logic [W-1:0]        mag;
  logic [W-1:0]        res_next;

  assign mag_a = opa[W-1] ? W'(0) - opa : opa;
  assign mag_b = opb[W-1] ? W'(0) - opb : opb;
  assign msum  = {1'b0, acc} + {1'b0, (sr[0] ? xm : W'(0))};
  assign rtry  = {rem, sr[NW-1]};
  assign rdiff = rtry - {1'b0, xm};
  assign qbit  = !rdiff[W];
  assign last  = (op == gff_pkg::OP_DIV) ? CW'(NW - 1) : CW'(W - 1);
  assign prod  = {acc, sr[W-1:0]};
  assign shv   = (op == gff_pkg::OP_MULF) ? (prod >> F) : (prod >> gff_pkg::ER_FRAC);

  always_comb begin
    if (op == gff_pkg::OP_DIV) begin
      big = |sr[NW-1:W-1];
      mag = sr[W-1:0];
    end else begin
      big = |shv[2*W-1:W-1];
      mag = shv[W-1:0];
    end
    if (dz) begin
      res_next = azero ? W'(0) : (asign ? VMIN : VMAX);
    end else if (big) begin
      res_next = neg ? VMIN : VMAX;
    end else if (neg) begin
      res_next = W'(0) - {1'b0, mag[W-2:0]};
    end else begin
      res_next = {1'b0, mag[W-2:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        op    <= req.op;
        neg   <= opa[W-1] ^ opb[W-1];
        asign <= opa[W-1];
        azero <= (opa == '0);
        dz    <= (req.op == gff_pkg::OP_DIV) && (opb == '0);
        cnt   <= '0;
        acc   <= '0;
        rem   <= '0;
        if (req.op == gff_pkg::OP_DIV) begin
          xm <= mag_b;
          sr <= {mag_a, F'(0)};
        end else begin
          xm <= mag_a;
          sr <= {F'(0), mag_b};
        end
        if ((req.op == gff_pkg::OP_DIV) && (opb == '0)) begin
          run <= 1'b0;
          fin <= 1'b1;
        end else begin
          run <= 1'b1;
          fin <= 1'b0;
        end
      end else if (run) begin
        if (op == gff_pkg::OP_DIV) begin
          rem <= qbit ? rdiff[W-1:0] : rtry[W-1:0];
          sr  <= {sr[NW-2:0], qbit};
        end else begin
          acc        <= msum[W:1];
          sr[W-1:0]  <= {msum[0], sr[W-1:1]};
        end
        cnt <= cnt + 1'b1;
        if (cnt == last) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
        res  <= res_next;
      end
    end
  end

endmodule

/* rtl/gap_friction_flag_hysteresis_top.sv */
// ----------------------------------------------------------------------------
// gap_friction_flag_hysteresis_top
// Uniaxial gap friction plus flag-shaped self-centering material step in
// signed fixed point, sequenced over one bit-serial multiply/divide unit.
// ----------------------------------------------------------------------------
// One item is in work at a time. Commit, revert and revert-to-start items
// go straight to the output. A trial item runs up to one friction multiply,
// three flag multiplies and the secant divide through the shared bit-serial
// unit; a step that stays inside one stage runs only one of the friction and
// flag sub-steps, and a step that does not move runs none of them. After
// reset and after every register write the block recomputes the slip offset
// and the flag constants (four divides and three multiplies), stalling input
// meanwhile.
// ----------------------------------------------------------------------------
module gap_friction_flag_hysteresis_top #(
  parameter int DATA_WIDTH = gff_pkg::DATA_WIDTH,
  parameter int FRAC_BITS  = gff_pkg::FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         mode,
  input  logic signed [31:0] strain,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] stress,
  output logic signed [31:0] tangent,
  output logic [1:0]         stage
);

  localparam int W  = DATA_WIDTH;
  localparam int XW = (W > 32) ? W : 32;
  localparam logic signed [W-1:0]  VMAX   = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  VMIN   = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [XW-1:0] VMAX_X = XW'(VMAX);
  localparam logic signed [XW-1:0] VMIN_X = XW'(VMIN);
  localparam logic signed [XW-1:0] O_MAX  = XW'(32'sh7fffffff);
  localparam logic signed [XW-1:0] O_MIN  = XW'(-32'sh80000000);
  localparam logic signed [W-1:0]  ONE    =
    (FRAC_BITS >= DATA_WIDTH - 1) ? VMAX : (W'(1) << FRAC_BITS);

  function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? VMIN : VMAX;
    return s[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? VMIN : VMAX;
    return s[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] neg_sat(input logic signed [W-1:0] a);
    return (a == VMIN) ? VMAX : -a;
  endfunction

  function automatic logic signed [W-1:0] from_reg(input logic [30:0] v);
    logic signed [XW-1:0] e;
    e = XW'(v);
    return (e > VMAX_X) ? VMAX : e[W-1:0];
  endfunction

  function automatic logic signed [31:0] to_out(input logic signed [W-1:0] v);
    logic signed [XW-1:0] e;
    e = XW'(v);
    if (e > O_MAX) return 32'sh7fffffff;
    if (e < O_MIN) return -32'sh80000000;
    return e[31:0];
  endfunction

  function automatic logic signed [W-1:0] from_in(input logic signed [31:0] v);
    logic signed [XW-1:0] e;
    e = XW'(v);
    if (e > VMAX_X) return VMAX;
    if (e < VMIN_X) return VMIN;
    return e[W-1:0];
  endfunction

  gff_pkg::state_t      state;
  gff_pkg::state_t      state_next;

  logic [30:0]          slip_force;
  logic [30:0]          gap_stiffness;
  logic [30:0]          gap_width;
  logic [30:0]          activation_force;
  logic [30:0]          initial_stiffness;
  logic [30:0]          post_stiffness;
  logic [16:0]          energy_ratio;

  logic signed [W-1:0]  committed_disp;
  logic signed [W-1:0]  committed_force;
  logic signed [W-1:0]  committed_tangent;
  logic [1:0]           committed_stage;
  logic signed [W-1:0]  trial_disp;
  logic signed [W-1:0]  trial_force;
  logic signed [W-1:0]  trial_tangent;
  logic [1:0]           trial_stage;
  logic signed [W-1:0]  slip_offset;

  logic signed [W-1:0]  uy;
  logic signed [W-1:0]  al;
  logic signed [W-1:0]  a_sc;
  logic signed [W-1:0]  m_sc;
  logic signed [W-1:0]  c_sc;
  logic signed [W-1:0]  top_sc;

  logic signed [W-1:0]  x_in;
  logic signed [W-1:0]  d_inc;
  logic signed [W-1:0]  s_u0;
  logic signed [W-1:0]  s_du;
  logic signed [W-1:0]  s_f0;
  logic                 s_flag;
  logic signed [W-1:0]  op2_u0;
  logic signed [W-1:0]  op2_du;
  logic                 op2_flag;
  logic                 two_ops;
  logic                 second;
  logic signed [W-1:0]  u_fl;
  logic signed [W-1:0]  fp;
  logic signed [W-1:0]  k1u;
  logic signed [W-1:0]  k2u;
  logic signed [W-1:0]  e1;
  logic signed [W-1:0]  e2;
  logic signed [W-1:0]  sres;

  logic signed [W-1:0]  g;
  logic signed [W-1:0]  ng;
  logic signed [W-1:0]  ks;
  logic signed [W-1:0]  k1;
  logic signed [W-1:0]  k2;
  logic signed [W-1:0]  f2;
  logic signed [W-1:0]  es;
  logic signed [W-1:0]  nes;
  logic signed [W-1:0]  init_tan;
  logic signed [W-1:0]  er_term;
  logic signed [18:0]   er_raw;
  logic signed [W-1:0]  off_calc;
  logic signed [W-1:0]  nal;
  logic signed [W-1:0]  nuy;
  logic signed [W-1:0]  flag_res;
  logic                 in_gap;
  logic                 cs2;
  logic                 dpos;
  logic                 spos;
  logic                 cfg_hit;
  logic                 slot;
  logic                 take;

  gff_pkg::arith_req_t  a_req;
  logic signed [W-1:0]  a_opa;
  logic signed [W-1:0]  a_opb;
  logic                 a_done;
  logic signed [W-1:0]  a_res;

  gff_arith #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_arith (
    .clk  (clk),
    .rst  (rst),
    .req  (a_req),
    .opa  (a_opa),
    .opb  (a_opb),
    .done (a_done),
    .res  (a_res)
  );

  assign g        = from_reg(gap_width);
  assign ng       = neg_sat(g);
  assign ks       = from_reg(gap_stiffness);
  assign k1       = from_reg(initial_stiffness);
  assign k2       = from_reg(post_stiffness);
  assign f2       = from_reg(activation_force);
  assign es       = (gap_width == '0) ? f2 : from_reg(slip_force);
  assign nes      = neg_sat(es);
  assign init_tan = (gap_width != '0) ? ks : k1;
  assign er_raw   = 19'sd65536 - $signed({1'b0, energy_ratio, 1'b0});
  assign er_term  = W'(er_raw);
  assign off_calc = sat_sub(g, a_res);
  assign nal      = neg_sat(al);
  assign nuy      = neg_sat(uy);
  assign in_gap   = (x_in >= ng) && (x_in <= g);
  assign cs2      = (committed_stage == gff_pkg::STAGE_SC);
  assign dpos     = !d_inc[W-1];
  assign spos     = !s_du[W-1];
  assign cfg_hit  = cfg_write && (cfg_index <= gff_pkg::CFG_ENERGY_RATIO);
  assign slot     = !out_valid || !out_stall;
  assign take     = in_valid && !in_stall;
  assign in_stall = (state != gff_pkg::ST_IDLE);

  always_comb begin
    if (spos) begin
      if ((u_fl < nal) && (fp > e1)) begin
        flag_res = e1;
      end else if ((nal <= u_fl) && (u_fl <= uy) && (fp > k1u)) begin
        flag_res = k1u;
      end else if ((u_fl > al) && (fp > e2)) begin
        flag_res = e2;
      end else begin
        flag_res = fp;
      end
    end else begin
      if ((u_fl > al) && (fp < e1)) begin
        flag_res = e1;
      end else if ((nuy <= u_fl) && (u_fl <= al) && (fp < k1u)) begin
        flag_res = k1u;
      end else if ((u_fl < nal) && (fp < e2)) begin
        flag_res = e2;
      end else begin
        flag_res = fp;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      gff_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = (mode == gff_pkg::MODE_TRIAL) ? gff_pkg::ST_T_D : gff_pkg::ST_OUT;
        end
      end
      gff_pkg::ST_R_SLIP:   state_next = gff_pkg::ST_R_SLIPW;
      gff_pkg::ST_R_SLIPW:  if (a_done) state_next = gff_pkg::ST_R_UYW;
      gff_pkg::ST_R_UYW:    if (a_done) state_next = gff_pkg::ST_R_AW;
      gff_pkg::ST_R_AW:     if (a_done) state_next = gff_pkg::ST_R_ALW;
      gff_pkg::ST_R_ALW:    if (a_done) state_next = gff_pkg::ST_R_MW;
      gff_pkg::ST_R_MW:     if (a_done) state_next = gff_pkg::ST_R_C;
      gff_pkg::ST_R_C:      state_next = gff_pkg::ST_R_CW;
      gff_pkg::ST_R_CW:     if (a_done) state_next = gff_pkg::ST_R_TW;
      gff_pkg::ST_R_TW:     if (a_done) state_next = gff_pkg::ST_IDLE;
      gff_pkg::ST_T_D:      state_next = gff_pkg::ST_T_CASE;
      gff_pkg::ST_T_CASE: begin
        state_next = (d_inc == '0) ? gff_pkg::ST_OUT : gff_pkg::ST_T_PREP1;
      end
      gff_pkg::ST_T_PREP1:  state_next = gff_pkg::ST_T_PREP2;
      gff_pkg::ST_T_PREP2: begin
        state_next = s_flag ? gff_pkg::ST_FL_START : gff_pkg::ST_FR_START;
      end
      gff_pkg::ST_FR_START: begin
        state_next = (s_du == '0) ? gff_pkg::ST_SUB_END : gff_pkg::ST_FR_MW;
      end
      gff_pkg::ST_FR_MW:    if (a_done) state_next = gff_pkg::ST_FR_CLAMP;
      gff_pkg::ST_FR_CLAMP: state_next = gff_pkg::ST_SUB_END;
      gff_pkg::ST_FL_START: begin
        state_next = (s_du == '0) ? gff_pkg::ST_SUB_END : gff_pkg::ST_FL_M1W;
      end
      gff_pkg::ST_FL_M1W:   if (a_done) state_next = gff_pkg::ST_FL_M2W;
      gff_pkg::ST_FL_M2W:   if (a_done) state_next = gff_pkg::ST_FL_M3W;
      gff_pkg::ST_FL_M3W:   if (a_done) state_next = gff_pkg::ST_FL_K;
      gff_pkg::ST_FL_K:     state_next = gff_pkg::ST_FL_SEL;
      gff_pkg::ST_FL_SEL:   state_next = gff_pkg::ST_SUB_END;
      gff_pkg::ST_SUB_END: begin
        if (two_ops && !second) begin
          state_next = op2_flag ? gff_pkg::ST_FL_START : gff_pkg::ST_FR_START;
        end else begin
          state_next = gff_pkg::ST_T_TAN;
        end
      end
      gff_pkg::ST_T_TAN:    state_next = gff_pkg::ST_T_TANW;
      gff_pkg::ST_T_TANW:   if (a_done) state_next = gff_pkg::ST_OUT;
      gff_pkg::ST_OUT:      if (slot) state_next = gff_pkg::ST_IDLE;
      default:              state_next = gff_pkg::ST_IDLE;
    endcase
    if (cfg_hit) state_next = gff_pkg::ST_R_SLIP;
  end

  always_comb begin
    a_req.start = 1'b0;
    a_req.op    = gff_pkg::OP_DIV;
    a_opa       = '0;
    a_opb       = '0;
    case (state)
      gff_pkg::ST_R_SLIP: begin
        a_req.start = 1'b1;
        a_opa = es;
        a_opb = ks;
      end
      gff_pkg::ST_R_SLIPW: begin
        a_req.start = a_done;
        a_opa = f2;
        a_opb = k1;
      end
      gff_pkg::ST_R_UYW: begin
        a_req.start = a_done;
        a_req.op    = gff_pkg::OP_MULQ;
        a_opa = f2;
        a_opb = er_term;
      end
      gff_pkg::ST_R_AW: begin
        a_req.start = a_done;
        a_opa = a_res;
        a_opb = k1;
      end
      gff_pkg::ST_R_ALW: begin
        a_req.start = a_done;
        a_opa = k2;
        a_opb = k1;
      end
      gff_pkg::ST_R_C: begin
        a_req.start = 1'b1;
        a_req.op    = gff_pkg::OP_MULF;
        a_opa = a_sc;
        a_opb = m_sc;
      end
      gff_pkg::ST_R_CW: begin
        a_req.start = a_done;
        a_req.op    = gff_pkg::OP_MULF;
        a_opa = k2;
        a_opb = uy;
      end
      gff_pkg::ST_FR_START: begin
        a_req.start = (s_du != '0);
        a_req.op    = gff_pkg::OP_MULF;
        a_opa = s_du;
        a_opb = ks;
      end
      gff_pkg::ST_FL_START: begin
        a_req.start = (s_du != '0);
        a_req.op    = gff_pkg::OP_MULF;
        a_opa = s_du;
        a_opb = k1;
      end
      gff_pkg::ST_FL_M1W: begin
        a_req.start = a_done;
        a_req.op    = gff_pkg::OP_MULF;
        a_opa = k1;
        a_opb = u_fl;
      end
      gff_pkg::ST_FL_M2W: begin
        a_req.start = a_done;
        a_req.op    = gff_pkg::OP_MULF;
        a_opa = k2;
        a_opb = u_fl;
      end
      gff_pkg::ST_T_TAN: begin
        a_req.start = 1'b1;
        a_opa = sat_sub(trial_force, committed_force);
        a_opb = d_inc;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= gff_pkg::ST_R_SLIP;
      out_valid         <= 1'b0;
      slip_force        <= gff_pkg::RST_SLIP_FORCE;
      gap_stiffness     <= gff_pkg::RST_GAP_STIFFNESS;
      gap_width         <= gff_pkg::RST_GAP_WIDTH;
      activation_force  <= gff_pkg::RST_ACTIVATION_FORCE;
      initial_stiffness <= gff_pkg::RST_INITIAL_STIFFNESS;
      post_stiffness    <= gff_pkg::RST_POST_STIFFNESS;
      energy_ratio      <= gff_pkg::RST_ENERGY_RATIO;
      committed_disp    <= '0;
      committed_force   <= '0;
      committed_tangent <= (gff_pkg::RST_GAP_WIDTH != '0) ?
                           from_reg(gff_pkg::RST_GAP_STIFFNESS) :
                           from_reg(gff_pkg::RST_INITIAL_STIFFNESS);
      committed_stage   <= gff_pkg::STAGE_GAP;
      trial_disp        <= '0;
      trial_force       <= '0;
      trial_tangent     <= (gff_pkg::RST_GAP_WIDTH != '0) ?
                           from_reg(gff_pkg::RST_GAP_STIFFNESS) :
                           from_reg(gff_pkg::RST_INITIAL_STIFFNESS);
      trial_stage       <= gff_pkg::STAGE_GAP;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        case (cfg_index)
          gff_pkg::CFG_SLIP_FORCE:        slip_force        <= cfg_data;
          gff_pkg::CFG_GAP_STIFFNESS:     gap_stiffness     <= cfg_data;
          gff_pkg::CFG_GAP_WIDTH:         gap_width         <= cfg_data;
          gff_pkg::CFG_ACTIVATION_FORCE:  activation_force  <= cfg_data;
          gff_pkg::CFG_INITIAL_STIFFNESS: initial_stiffness <= cfg_data;
          gff_pkg::CFG_POST_STIFFNESS:    post_stiffness    <= cfg_data;
          gff_pkg::CFG_ENERGY_RATIO:      energy_ratio      <= cfg_data[16:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if ((state == gff_pkg::ST_OUT) && slot) out_valid <= 1'b1;
      case (state)
        gff_pkg::ST_IDLE: begin
          if (take) begin
            case (mode)
              gff_pkg::MODE_COMMIT: begin
                committed_disp    <= trial_disp;
                committed_force   <= trial_force;
                committed_tangent <= trial_tangent;
                committed_stage   <= trial_stage;
              end
              gff_pkg::MODE_REVERT: begin
                trial_disp    <= committed_disp;
                trial_force   <= committed_force;
                trial_tangent <= committed_tangent;
                trial_stage   <= committed_stage;
              end
              gff_pkg::MODE_START: begin
                committed_disp    <= '0;
                committed_force   <= '0;
                committed_tangent <= init_tan;
                committed_stage   <= gff_pkg::STAGE_GAP;
                trial_disp        <= '0;
                trial_force       <= '0;
                trial_tangent     <= init_tan;
                trial_stage       <= gff_pkg::STAGE_GAP;
              end
              default: ;
            endcase
          end
        end
        gff_pkg::ST_T_CASE: begin
          if (d_inc == '0) begin
            trial_disp    <= committed_disp;
            trial_force   <= committed_force;
            trial_tangent <= committed_tangent;
            trial_stage   <= committed_stage;
          end else begin
            trial_disp  <= x_in;
            trial_stage <= in_gap ? gff_pkg::STAGE_GAP : gff_pkg::STAGE_SC;
          end
        end
        gff_pkg::ST_SUB_END: begin
          if (!(two_ops && !second)) trial_force <= sres;
        end
        gff_pkg::ST_T_TANW: begin
          if (a_done) trial_tangent <= a_res;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      gff_pkg::ST_IDLE: begin
        if (take) x_in <= from_in(strain);
      end
      gff_pkg::ST_R_SLIPW: begin
        if (a_done) slip_offset <= off_calc[W-1] ? W'(0) : off_calc;
      end
      gff_pkg::ST_R_UYW: if (a_done) uy <= a_res;
      gff_pkg::ST_R_AW:  if (a_done) a_sc <= a_res;
      gff_pkg::ST_R_ALW: if (a_done) al <= a_res;
      gff_pkg::ST_R_MW:  if (a_done) m_sc <= sat_sub(ONE, a_res);
      gff_pkg::ST_R_CW:  if (a_done) c_sc <= a_res;
      gff_pkg::ST_R_TW:  if (a_done) top_sc <= sat_sub(f2, a_res);
      gff_pkg::ST_T_D: begin
        d_inc <= sat_sub(x_in, committed_disp);
      end
      gff_pkg::ST_T_PREP1: begin
        s_f0   <= committed_force;
        second <= 1'b0;
        if (!cs2 && (trial_stage == gff_pkg::STAGE_GAP)) begin
          s_flag  <= 1'b0;
          s_du    <= d_inc;
          two_ops <= 1'b0;
        end else if (!cs2) begin
          s_flag   <= 1'b0;
          s_du     <= dpos ? sat_sub(g, committed_disp) : sat_sub(ng, committed_disp);
          op2_u0   <= dpos ? sat_sub(g, slip_offset) : sat_sub(slip_offset, g);
          op2_flag <= 1'b1;
          two_ops  <= 1'b1;
        end else if (trial_stage == gff_pkg::STAGE_SC) begin
          s_flag  <= 1'b1;
          s_u0    <= committed_disp[W-1] ? sat_add(committed_disp, slip_offset) :
                                           sat_sub(committed_disp, slip_offset);
          s_du    <= d_inc;
          two_ops <= 1'b0;
        end else if (!dpos) begin
          s_flag   <= 1'b1;
          s_u0     <= sat_sub(committed_disp, slip_offset);
          s_du     <= sat_sub(g, committed_disp);
          op2_flag <= 1'b0;
          two_ops  <= 1'b1;
        end else begin
          s_flag   <= 1'b1;
          s_u0     <= sat_add(committed_disp, slip_offset);
          s_du     <= sat_sub(ng, committed_disp);
          op2_flag <= 1'b0;
          two_ops  <= 1'b1;
        end
      end
      gff_pkg::ST_T_PREP2: begin
        if (!cs2) begin
          op2_du <= sat_sub(d_inc, s_du);
        end else if (!dpos) begin
          op2_du <= sat_sub(x_in, g);
        end else begin
          op2_du <= sat_add(x_in, g);
        end
      end
      gff_pkg::ST_FR_START: begin
        if (s_du == '0) sres <= s_f0;
      end
      gff_pkg::ST_FR_MW: begin
        if (a_done) fp <= sat_add(s_f0, a_res);
      end
      gff_pkg::ST_FR_CLAMP: begin
        sres <= (fp > es) ? es : ((fp < nes) ? nes : fp);
      end
      gff_pkg::ST_FL_START: begin
        if (s_du == '0) sres <= s_f0;
        u_fl <= sat_add(s_u0, s_du);
      end
      gff_pkg::ST_FL_M1W: if (a_done) fp <= sat_add(s_f0, a_res);
      gff_pkg::ST_FL_M2W: if (a_done) k1u <= a_res;
      gff_pkg::ST_FL_M3W: if (a_done) k2u <= a_res;
      gff_pkg::ST_FL_K: begin
        e1 <= spos ? sat_sub(k2u, c_sc) : sat_add(k2u, c_sc);
        e2 <= spos ? sat_add(k2u, top_sc) : sat_sub(k2u, top_sc);
      end
      gff_pkg::ST_FL_SEL: sres <= flag_res;
      gff_pkg::ST_SUB_END: begin
        if (two_ops && !second) begin
          second <= 1'b1;
          s_f0   <= sres;
          s_u0   <= op2_u0;
          s_du   <= op2_du;
          s_flag <= op2_flag;
        end
      end
      gff_pkg::ST_OUT: begin
        if (slot) begin
          stress  <= to_out(trial_force);
          tangent <= to_out(trial_tangent);
          stage   <= trial_stage;
        end
      end
      default: ;
    endcase
  end

endmodule

/* rtl/gff_checker.sv */
// ----------------------------------------------------------------------------
// gff_checker
// Port-level checks of the gap friction flag hysteresis block, bound to
// the top level.
// ----------------------------------------------------------------------------
module gff_checker (
  input logic               clk,
  input logic               rst,
  input logic               cfg_write,
  input logic [2:0]         cfg_index,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] stress,
  input logic signed [31:0] tangent,
  input logic [1:0]         stage
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(stress) && $stable(tangent)
      && $stable(stage))
    else $error("result changed while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second transfer taken while an item is in work");

  a_reset_refresh: assert property (@(posedge clk)
    rst |=> in_stall)
    else $error("input open before constants are refreshed");

  a_cfg_refresh: assert property (@(posedge clk) disable iff (rst)
    cfg_write && (cfg_index <= gff_pkg::CFG_ENERGY_RATIO) |=> in_stall)
    else $error("input open after register write");

endmodule

bind gap_friction_flag_hysteresis_top gff_checker u_gff_checker (.*);

/* sim/gap_friction_flag_hysteresis_top_test.sv */
// ----------------------------------------------------------------------------
// gap_friction_flag_hysteresis_top_test
// Self-checking bench for the gap friction flag hysteresis block. A driver
// sends trial, commit, revert and revert-to-start items with random gaps.
// A monitor applies random back-pressure and compares each response with a
// bit-exact fixed-point material predictor. The run goes through several
// register settings, including zero gap, zero stiffness and extreme values.
// ----------------------------------------------------------------------------
module gap_friction_flag_hysteresis_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;

  typedef struct {
    logic [1:0]  md;
    logic [31:0] x;
  } mat_item_t;

  typedef struct {
    logic signed [31:0] frc;
    logic signed [31:0] tan;
    logic [1:0]         stg;
  } mat_resp_t;

  logic               clk = 0;
  logic               rst = 1;
  logic               cfg_write = 0;
  logic [2:0]         cfg_index = '0;
  logic [30:0]        cfg_data = '0;
  logic               in_valid = 0;
  logic               in_stall;
  logic [1:0]         mode = gff_pkg::MODE_TRIAL;
  logic signed [31:0] strain = '0;
  logic               out_valid;
  logic               out_stall = 0;
  logic signed [31:0] stress;
  logic signed [31:0] tangent;
  logic [1:0]         stage;

  gap_friction_flag_hysteresis_top u_top (.*);

  always #1 clk = ~clk;

  // material registers and state
  longint r_slip, r_kgap, r_gap, r_fact, r_k1, r_k2, r_ratio;
  longint c_disp, c_frc, c_tan, t_disp, t_frc, t_tan, slip_ofs;
  logic [1:0] c_stg, t_stg;

  mat_item_t pending_items[$];
  mat_resp_t expected_resp[$];
  int  n_sent = 0, n_checked = 0, n_errors = 0;
  int  send_gap = 0, stall_left = 0;
  bit  burst = 0;

  function automatic longint sat(longint v);
    return v > VMAX ? VMAX : (v < VMIN ? VMIN : v);
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint neg_s(longint v);
    return sat(-v);
  endfunction

  function automatic longint add_s(longint a, longint b);
    return sat(a + b);
  endfunction

  function automatic longint sub_s(longint a, longint b);
    return sat(a - b);
  endfunction

  function automatic longint mul_shr(longint a, longint b, int sh);
    longint p;
    p = (mag(a) * mag(b)) >>> sh;
    return ((a < 0) != (b < 0)) ? sat(-p) : sat(p);
  endfunction

  function automatic longint div_q(longint a, longint b);
    longint q;
    if (b == 0) return a == 0 ? 0 : (a > 0 ? VMAX : VMIN);
    q = (mag(a) <<< gff_pkg::FRAC_BITS) / mag(b);
    return ((a < 0) != (b < 0)) ? sat(-q) : sat(q);
  endfunction

  function automatic longint slip_eff();
    return r_gap == 0 ? r_fact : r_slip;
  endfunction

  function automatic void update_offset();
    longint o;
    o = sub_s(r_gap, div_q(slip_eff(), r_kgap));
    slip_ofs = o < 0 ? 0 : o;
  endfunction

  function automatic void restart_state();
    c_disp = 0; c_frc = 0; t_disp = 0; t_frc = 0;
    c_tan = r_gap != 0 ? r_kgap : r_k1;
    t_tan = c_tan;
    c_stg = gff_pkg::STAGE_GAP; t_stg = gff_pkg::STAGE_GAP;
    update_offset();
  endfunction

  function automatic longint friction_step(longint f0, longint du);
    longint fp, s;
    s = slip_eff();
    if (du == 0) return f0;
    fp = add_s(f0, mul_shr(du, r_kgap, gff_pkg::FRAC_BITS));
    if (fp > s) return s;
    if (fp < neg_s(s)) return neg_s(s);
    return fp;
  endfunction

  function automatic longint flag_step(longint u0, longint f0, longint du);
    longint u, uy, fp, a, al, m, c, top, k1u, k2u;
    if (du == 0) return f0;
    u   = add_s(u0, du);
    uy  = div_q(r_fact, r_k1);
    fp  = add_s(f0, mul_shr(du, r_k1, gff_pkg::FRAC_BITS));
    a   = mul_shr(r_fact, sat(65536 - 2 * r_ratio), 16);
    al  = div_q(a, r_k1);
    m   = sub_s(64'sd1 <<< gff_pkg::FRAC_BITS, div_q(r_k2, r_k1));
    c   = mul_shr(a, m, gff_pkg::FRAC_BITS);
    top = sub_s(r_fact, mul_shr(r_k2, uy, gff_pkg::FRAC_BITS));
    k1u = mul_shr(r_k1, u, gff_pkg::FRAC_BITS);
    k2u = mul_shr(r_k2, u, gff_pkg::FRAC_BITS);
    if (du > 0) begin
      if (u < neg_s(al) && fp > sub_s(k2u, c)) return sub_s(k2u, c);
      if (neg_s(al) <= u && u <= uy && fp > k1u) return k1u;
      if (u > al && fp > add_s(k2u, top)) return add_s(k2u, top);
      return fp;
    end
    if (u > al && fp < add_s(k2u, c)) return add_s(k2u, c);
    if (neg_s(uy) <= u && u <= al && fp < k1u) return k1u;
    if (u < neg_s(al) && fp < sub_s(k2u, top)) return sub_s(k2u, top);
    return fp;
  endfunction

  function automatic void trial_step(longint x);
    longint g, d, f, du1, u0;
    g = r_gap;
    t_disp = c_disp; t_frc = c_frc; t_tan = c_tan; t_stg = c_stg;
    d = sub_s(x, c_disp);
    if (d == 0) return;
    t_disp = x;
    t_stg = (x >= neg_s(g) && x <= g) ? gff_pkg::STAGE_GAP : gff_pkg::STAGE_SC;
    if (c_stg != gff_pkg::STAGE_SC && t_stg == gff_pkg::STAGE_GAP) begin
      f = friction_step(c_frc, d);
    end else if (c_stg != gff_pkg::STAGE_SC) begin
      du1 = d > 0 ? sub_s(g, c_disp) : sub_s(neg_s(g), c_disp);
      u0  = d > 0 ? sub_s(g, slip_ofs) : sub_s(slip_ofs, g);
      f = flag_step(u0, friction_step(c_frc, du1), sub_s(d, du1));
    end else if (t_stg == gff_pkg::STAGE_SC) begin
      f = flag_step(c_disp >= 0 ? sub_s(c_disp, slip_ofs) : add_s(c_disp, slip_ofs),
                    c_frc, d);
    end else if (d < 0) begin
      f = friction_step(flag_step(sub_s(c_disp, slip_ofs), c_frc, sub_s(g, c_disp)),
                        sub_s(x, g));
    end else begin
      f = friction_step(flag_step(add_s(c_disp, slip_ofs), c_frc,
                                  sub_s(neg_s(g), c_disp)), add_s(x, g));
    end
    t_frc = f;
    t_tan = div_q(sub_s(f, c_frc), d);
  endfunction

  function automatic mat_resp_t material_step(mat_item_t it);
    mat_resp_t r;
    case (it.md)
      gff_pkg::MODE_TRIAL: trial_step(longint'($signed(it.x)));
      gff_pkg::MODE_COMMIT: begin
        c_disp = t_disp; c_frc = t_frc; c_tan = t_tan; c_stg = t_stg;
      end
      gff_pkg::MODE_REVERT: begin
        t_disp = c_disp; t_frc = c_frc; t_tan = c_tan; t_stg = c_stg;
      end
      default: restart_state();
    endcase
    r.frc = t_frc[31:0];
    r.tan = t_tan[31:0];
    r.stg = t_stg;
    return r;
  endfunction

  function automatic void set_register(logic [2:0] idx, longint v);
    case (idx)
      gff_pkg::CFG_SLIP_FORCE:        r_slip  = v & 64'h7FFFFFFF;
      gff_pkg::CFG_GAP_STIFFNESS:     r_kgap  = v & 64'h7FFFFFFF;
      gff_pkg::CFG_GAP_WIDTH:         r_gap   = v & 64'h7FFFFFFF;
      gff_pkg::CFG_ACTIVATION_FORCE:  r_fact  = v & 64'h7FFFFFFF;
      gff_pkg::CFG_INITIAL_STIFFNESS: r_k1    = v & 64'h7FFFFFFF;
      gff_pkg::CFG_POST_STIFFNESS:    r_k2    = v & 64'h7FFFFFFF;
      gff_pkg::CFG_ENERGY_RATIO:      r_ratio = v & 64'h1FFFF;
      default: ;
    endcase
    update_offset();
  endfunction

  function automatic int draw_wait();
    return burst ? 0 : $urandom_range(0, 5);
  endfunction

  // driver
  always @(posedge clk) begin
    mat_item_t it;
    if (rst) begin
      in_valid <= 0;
    end else if (in_valid && !in_stall) begin
      it.md = mode;
      it.x = strain;
      expected_resp.push_back(material_step(it));
      n_sent++;
      send_gap = draw_wait();
      if (send_gap == 0 && pending_items.size() > 0) begin
        it = pending_items.pop_front();
        mode <= it.md;
        strain <= it.x;
      end else begin
        in_valid <= 0;
      end
    end else if (!in_valid) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        mode <= it.md;
        strain <= it.x;
        in_valid <= 1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    mat_resp_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_resp.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected transfer stress=%h tangent=%h stage=%0d",
                   $time, stress, tangent, stage);
        end else begin
          e = expected_resp.pop_front();
          n_checked++;
          if (e.frc !== stress || e.tan !== tangent || e.stg !== stage) begin
            n_errors++;
            $display("%0t: mismatch exp %h/%h/%0d got %h/%h/%0d", $time,
                     e.frc, e.tan, e.stg, stress, tangent, stage);
          end
        end
        stall_left = draw_wait();
        out_stall <= stall_left > 0;
      end else if (out_stall) begin
        if (stall_left <= 1) out_stall <= 0;
        stall_left--;
      end
    end
  end

  function automatic logic [31:0] pick_strain();
    longint span;
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: begin
        span = r_gap * 3 + 65536 * ($urandom_range(0, 1) ? 1 : 20);
        if (span > 64'sd1073741824) span = 64'sd1073741824;
        return 32'(longint'($urandom_range(0, 32'(2 * span))) - span);
      end
    endcase
  endfunction

  task automatic queue_item(logic [1:0] md, logic [31:0] x);
    mat_item_t it;
    it.md = md;
    it.x = x;
    pending_items.push_back(it);
  endtask

  task automatic drain();
    @(negedge clk);
    while (pending_items.size() > 0 || in_valid || expected_resp.size() > 0)
      @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_register(logic [2:0] idx, longint v);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= v[30:0];
    @(posedge clk);
    set_register(idx, v);
    cfg_write <= 0;
    @(posedge clk);
  endtask

  task automatic load_setting(longint s, longint kg, longint g, longint fa,
                              longint k1, longint k2, longint er);
    drain();
    write_register(gff_pkg::CFG_SLIP_FORCE, s);
    write_register(gff_pkg::CFG_GAP_STIFFNESS, kg);
    write_register(gff_pkg::CFG_GAP_WIDTH, g);
    write_register(gff_pkg::CFG_ACTIVATION_FORCE, fa);
    write_register(gff_pkg::CFG_INITIAL_STIFFNESS, k1);
    write_register(gff_pkg::CFG_POST_STIFFNESS, k2);
    write_register(gff_pkg::CFG_ENERGY_RATIO, er);
  endtask

  task automatic random_phase(int n);
    int r;
    burst = $urandom_range(0, 3) == 0;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 19);
      if (r < 12) begin
        queue_item(gff_pkg::MODE_TRIAL, pick_strain());
        if ($urandom_range(0, 3) != 0) queue_item(gff_pkg::MODE_COMMIT, $urandom);
        i++;
      end else if (r < 15) queue_item(gff_pkg::MODE_COMMIT, $urandom);
      else if (r < 18) queue_item(gff_pkg::MODE_REVERT, $urandom);
      else if (r < 19) queue_item(gff_pkg::MODE_START, $urandom);
      else queue_item(gff_pkg::MODE_TRIAL, $urandom);
    end
    drain();
  endtask

  initial begin
    r_slip = gff_pkg::RST_SLIP_FORCE; r_kgap = gff_pkg::RST_GAP_STIFFNESS;
    r_gap = gff_pkg::RST_GAP_WIDTH; r_fact = gff_pkg::RST_ACTIVATION_FORCE;
    r_k1 = gff_pkg::RST_INITIAL_STIFFNESS; r_k2 = gff_pkg::RST_POST_STIFFNESS;
    r_ratio = gff_pkg::RST_ENERGY_RATIO;
    restart_state();
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    burst = 1;
    queue_item(gff_pkg::MODE_TRIAL, 32'd0);
    queue_item(gff_pkg::MODE_TRIAL, 32'd30000);
    queue_item(gff_pkg::MODE_COMMIT, 32'd0);
    queue_item(gff_pkg::MODE_TRIAL, 32'd200000);
    queue_item(gff_pkg::MODE_COMMIT, 32'd0);
    queue_item(gff_pkg::MODE_TRIAL, 32'd400000);
    queue_item(gff_pkg::MODE_COMMIT, 32'd0);
    queue_item(gff_pkg::MODE_TRIAL, 32'd10000);
    queue_item(gff_pkg::MODE_COMMIT, 32'd0);
    queue_item(gff_pkg::MODE_TRIAL, -32'sd300000);
    queue_item(gff_pkg::MODE_REVERT, 32'd0);
    queue_item(gff_pkg::MODE_TRIAL, 32'h7FFFFFFF);
    queue_item(gff_pkg::MODE_COMMIT, 32'd0);
    queue_item(gff_pkg::MODE_TRIAL, 32'h80000000);
    queue_item(gff_pkg::MODE_COMMIT, 32'hFFFFFFFF);
    queue_item(gff_pkg::MODE_TRIAL, 32'h80000000);
    queue_item(gff_pkg::MODE_START, 32'h12345678);
    queue_item(gff_pkg::MODE_TRIAL, -32'sd70000);
    queue_item(gff_pkg::MODE_COMMIT, 32'd0);
    queue_item(gff_pkg::MODE_TRIAL, 32'd70000);
    queue_item(gff_pkg::MODE_START, 32'd0);
    drain();
    burst = 0;
    random_phase(120);

    load_setting(65536, 131072, 0, 98304, 196608, 13107, 0);
    random_phase(90);
    load_setting(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                 32'h7FFFFFFF, 32'h7FFFFFFF, 65536);
    random_phase(70);
    load_setting(1, 1, 1, 1, 1, 1, 131071);
    random_phase(70);
    load_setting(40000, 0, 131072, 50000, 0, 0, 20000);
    queue_item(gff_pkg::MODE_TRIAL, 32'd500000);
    queue_item(gff_pkg::MODE_COMMIT, 32'd0);
    queue_item(gff_pkg::MODE_TRIAL, -32'sd20000);
    random_phase(60);
    load_setting($urandom_range(1, 400000), $urandom_range(1, 400000),
                 $urandom_range(0, 300000), $urandom_range(1, 400000),
                 $urandom_range(1, 400000), $urandom_range(1, 100000),
                 $urandom_range(0, 65536));
    queue_item(gff_pkg::MODE_START, 32'd0);
    random_phase(150);
    load_setting(20000, 65536, 65536, 131072, 131072, 20000, 49152);
    random_phase(150);

    drain();
    $display("Checked %0d of %0d transfers over seven register settings,", n_checked,
             n_sent);
    $display("with trial, commit and both reverts under random gaps and back-pressure.");
    if (n_errors == 0 && expected_resp.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Timeout with %0d responses outstanding", expected_resp.size());
    $display("FAIL");
    $finish;
  end

endmodule
